// ===== hw/rtl/mqbf_pkg.sv =====
// Shared types and constants for the multi-queue byte FIFO.
`default_nettype none
package mqbf_pkg;

	localparam int NUM_QUEUES_DEF  = 8;
	localparam int QUEUE_DEPTH_DEF = 1024;

	localparam int QID_W    = 3;
	localparam int BYTE_W   = 8;
	localparam int STATUS_W = 2;

	localparam logic CMD_READ  = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Outcome of one access as decided against the pointer file.
	typedef struct packed {
		logic                do_read;
		logic                do_write;
		logic [STATUS_W-1:0] status;
	} access_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mqbf_req_if.sv =====
// Request channel: one byte read or write on one queue.
`default_nettype none
interface mqbf_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [mqbf_pkg::QID_W-1:0]    queue_id;
	logic [mqbf_pkg::BYTE_W-1:0]   write_byte;
	logic                          last_of_request;

	modport source (output valid, command, queue_id, write_byte, last_of_request,
		input ready);
	modport sink (input valid, command, queue_id, write_byte, last_of_request,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mqbf_rsp_if.sv =====
// Response channel: one result per request.
`default_nettype none
interface mqbf_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [mqbf_pkg::BYTE_W-1:0]     read_byte;
	logic [mqbf_pkg::STATUS_W-1:0]   status;
	logic                            request_done;

	modport source (output valid, read_byte, status, request_done, input ready);
	modport sink (input valid, read_byte, status, request_done, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mqbf_ptr_ctrl.sv =====
// Head and tail pointer file with the empty/full decision for each access.
`default_nettype none
module mqbf_ptr_ctrl #(
	parameter int NUM_QUEUES  = mqbf_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mqbf_pkg::QUEUE_DEPTH_DEF,
	localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1,
	localparam int PW  = $clog2(QUEUE_DEPTH)
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       accept,
	input  wire logic                       command,
	input  wire logic [mqbf_pkg::QID_W-1:0] queue_id,
	output mqbf_pkg::access_t               acc,
	output logic [QIW+PW-1:0]               addr
);

	localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

	logic [PW-1:0] head_q [NUM_QUEUES];
	logic [PW-1:0] tail_q [NUM_QUEUES];

	logic [QIW+mqbf_pkg::QID_W-1:0] qid_ext;
	logic [QIW-1:0]                 qidx;
	logic                           q_exists;
	logic [PW-1:0]                  h, t, h_next, t_next;

	assign qid_ext  = {{QIW{1'b0}}, queue_id};
	assign qidx     = qid_ext[QIW-1:0];
	assign q_exists = (32'(queue_id) < NUM_QUEUES);

	assign h      = head_q[qidx];
	assign t      = tail_q[qidx];
	assign h_next = (h == PTR_LAST) ? '0 : h + PW'(1);
	assign t_next = (t == PTR_LAST) ? '0 : t + PW'(1);

	always_comb begin
		acc.do_read  = 1'b0;
		acc.do_write = 1'b0;
		acc.status   = mqbf_pkg::ST_OK;
		if (command == mqbf_pkg::CMD_WRITE) begin
			if (!q_exists || t_next == h) begin
				acc.status = mqbf_pkg::ST_FULL;
			end else begin
				acc.do_write = 1'b1;
			end
		end else begin
			if (!q_exists || h == t) begin
				acc.status = mqbf_pkg::ST_EMPTY;
			end else begin
				acc.do_read = 1'b1;
			end
		end
	end

	// Each queue owns a row of 2**PW bytes, so the address is a plain concatenation.
	assign addr = {qidx, (command == mqbf_pkg::CMD_WRITE) ? t : h};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (accept) begin
			if (acc.do_read) begin
				head_q[qidx] <= h_next;
			end
			if (acc.do_write) begin
				tail_q[qidx] <= t_next;
			end
		end
	end

	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(acc.do_read && acc.do_write))
		else $error("read and write granted together");

	a_tail_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && acc.do_write) |=> (tail_q[$past(qidx)] == $past(t_next)))
		else $error("tail did not advance after a stored write");

	a_head_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && acc.do_read) |=> (head_q[$past(qidx)] == $past(h_next)))
		else $error("head did not advance after a successful read");

endmodule
`default_nettype wire

// ===== hw/rtl/mqbf_store.sv =====
// Shared byte store with one port and registered read data.
`default_nettype none
module mqbf_store #(
	parameter int AW = 13
) (
	input  wire logic                        clk,
	input  wire logic                        wr_en,
	input  wire logic                        rd_en,
	input  wire logic [AW-1:0]               addr,
	input  wire logic [mqbf_pkg::BYTE_W-1:0] wdata,
	output logic      [mqbf_pkg::BYTE_W-1:0] rdata
);

	logic [mqbf_pkg::BYTE_W-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/multi_queue_byte_fifo.sv =====
// Top level of the multi-queue byte FIFO.
// A bank of NUM_QUEUES byte FIFOs, each a ring of QUEUE_DEPTH entries holding at most
// QUEUE_DEPTH - 1 bytes, in one shared single-port store. Every request (a read or a
// write of one byte on one queue) yields exactly one response, in order: a read on an
// empty queue answers status 1 and byte 0, a write on a full queue is dropped with
// status 2, and a queue number at or above NUM_QUEUES acts as empty for reads and full
// for writes. A new request is taken every cycle while responses are taken; the response
// is presented from the output register, fed by the registered read of the byte store
// and the stage register, both loaded at the transfer edge. The output
// register and the stage before it let one request be taken while a response waits.
// Pointers clear at reset; store contents are undefined until written.
`default_nettype none
module multi_queue_byte_fifo #(
	parameter int NUM_QUEUES  = mqbf_pkg::NUM_QUEUES_DEF,
	parameter int QUEUE_DEPTH = mqbf_pkg::QUEUE_DEPTH_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	mqbf_req_if.sink   req,
	mqbf_rsp_if.source rsp
);

	localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PW  = $clog2(QUEUE_DEPTH);
	localparam int AW  = QIW + PW;

	mqbf_pkg::access_t           acc;
	logic [AW-1:0]               addr;
	logic [mqbf_pkg::BYTE_W-1:0] rdata;
	logic                        accept;
	logic                        advance;

	logic                          v_s1;
	logic                          rd_s1;
	logic [mqbf_pkg::STATUS_W-1:0] status_s1;
	logic                          last_s1;

	logic                          out_v_q;
	logic [mqbf_pkg::BYTE_W-1:0]   read_byte_q;
	logic [mqbf_pkg::STATUS_W-1:0] status_q;
	logic                          done_q;

	assign advance   = v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !v_s1 || advance;
	assign accept    = req.valid && req.ready;

	mqbf_ptr_ctrl #(
		.NUM_QUEUES (NUM_QUEUES),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ptr (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.command (req.command),
		.queue_id(req.queue_id),
		.acc     (acc),
		.addr    (addr)
	);

	mqbf_store #(
		.AW(AW)
	) u_store (
		.clk  (clk),
		.wr_en(accept && acc.do_write),
		.rd_en(accept && acc.do_read),
		.addr (addr),
		.wdata(req.write_byte),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1     <= acc.do_read;
			status_s1 <= acc.status;
			last_s1   <= req.last_of_request;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	// The store holds its read data until the next read, which cannot start before
	// the stage that owns it has moved on.
	always_ff @(posedge clk) begin
		if (advance) begin
			read_byte_q <= rd_s1 ? rdata : '0;
			status_q    <= status_s1;
			done_q      <= last_s1;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.read_byte    = read_byte_q;
	assign rsp.status       = status_q;
	assign rsp.request_done = done_q;

endmodule
`default_nettype wire
